### src/parabolic_stop_and_reverse_unit_macros.svh
// Assertion macros for the parabolic stop-and-reverse unit.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef PARABOLIC_STOP_AND_REVERSE_UNIT_MACROS_SVH
`define PARABOLIC_STOP_AND_REVERSE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define SAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sar_pkg.sv
// Shared types and constants of the parabolic stop-and-reverse unit.
// No dependencies.
`default_nettype none

package sar_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL_START = 2'd0,
    CFG_ACCEL_STEP  = 2'd1,
    CFG_ACCEL_LIMIT = 2'd2
  } cfg_idx_e;

  // Register reset values, Q0.16 (about 0.02 and 0.2)
  localparam logic [CfgDataW-1:0] ACCEL_START_RST = 16'd1311;
  localparam logic [CfgDataW-1:0] ACCEL_STEP_RST  = 16'd1311;
  localparam logic [CfgDataW-1:0] ACCEL_LIMIT_RST = 16'd13107;

  // Flags of one step of the core
  typedef struct packed {
    logic valid;     // the bar gives a result
    logic is_short;
    logic reversed;
  } sar_flags_t;

endpackage

`default_nettype wire

### src/sar_if.sv
// Request channels of the parabolic stop-and-reverse unit: price bars in,
// stop levels out. Valid/ready handshake; no dependencies.
`default_nettype none

interface sar_bar_if #(
  parameter int unsigned PRICE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] bar_high;
  logic [PRICE_BITS-1:0] bar_low;
  logic                  series_start;

  modport source (output valid, bar_high, bar_low, series_start, input ready);
  modport sink   (input valid, bar_high, bar_low, series_start, output ready);
endinterface

interface sar_res_if #(
  parameter int unsigned PRICE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] stop_level;
  logic                  is_short;
  logic                  reversed;

  modport source (output valid, stop_level, is_short, reversed, input ready);
  modport sink   (input valid, stop_level, is_short, reversed, output ready);
endinterface

`default_nettype wire

### src/sar_cfg.sv
// Acceleration registers (start, step, limit) behind the plain write port.
// Depends on sar_pkg.
`default_nettype none

module sar_cfg #(
  parameter int unsigned ACCEL_FRAC_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sar_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [sar_pkg::CfgDataW-1:0]    cfg_data_i,
  output logic      [ACCEL_FRAC_BITS-1:0]      accel_start_o,
  output logic      [ACCEL_FRAC_BITS-1:0]      accel_step_o,
  output logic      [ACCEL_FRAC_BITS-1:0]      accel_limit_o
);

  // bits of the write data that survive the Q0.F format
  localparam int unsigned KeepW =
    (ACCEL_FRAC_BITS < sar_pkg::CfgDataW) ? ACCEL_FRAC_BITS : sar_pkg::CfgDataW;

  logic [ACCEL_FRAC_BITS-1:0] wr_val;
  logic [ACCEL_FRAC_BITS-1:0] start_q, step_q, limit_q;

  assign wr_val = ACCEL_FRAC_BITS'(cfg_data_i[KeepW-1:0]);

  // register file, indices beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= ACCEL_FRAC_BITS'(sar_pkg::ACCEL_START_RST);
      step_q  <= ACCEL_FRAC_BITS'(sar_pkg::ACCEL_STEP_RST);
      limit_q <= ACCEL_FRAC_BITS'(sar_pkg::ACCEL_LIMIT_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sar_pkg::CFG_ACCEL_START: start_q <= wr_val;
        sar_pkg::CFG_ACCEL_STEP:  step_q  <= wr_val;
        sar_pkg::CFG_ACCEL_LIMIT: limit_q <= wr_val;
        default: ;
      endcase
    end
  end

  assign accel_start_o = start_q;
  assign accel_step_o  = step_q;
  assign accel_limit_o = limit_q;

endmodule

`default_nettype wire

### src/sar_core.sv
// Stop-and-reverse recurrence: series state, position, extreme, stops and
// acceleration, updated once per bar. Depends on sar_pkg.
`default_nettype none

module sar_core #(
  parameter int unsigned PRICE_BITS      = 32,
  parameter int unsigned ACCEL_FRAC_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       fire_i,
  input  wire logic [PRICE_BITS-1:0]      high_i,
  input  wire logic [PRICE_BITS-1:0]      low_i,
  input  wire logic                       series_start_i,
  input  wire logic [ACCEL_FRAC_BITS-1:0] accel_start_i,
  input  wire logic [ACCEL_FRAC_BITS-1:0] accel_step_i,
  input  wire logic [ACCEL_FRAC_BITS-1:0] accel_limit_i,
  output logic      [PRICE_BITS-1:0]      stop_level_o,
  output sar_pkg::sar_flags_t             flags_o
);

  localparam int unsigned PW = PRICE_BITS;
  localparam int unsigned FW = ACCEL_FRAC_BITS;
  localparam int unsigned MW = PRICE_BITS + ACCEL_FRAC_BITS;

  // series state codes
  localparam logic [1:0] SER_NONE  = 2'd0;
  localparam logic [1:0] SER_FIRST = 2'd1;
  localparam logic [1:0] SER_RUN   = 2'd2;

  logic [1:0]    ser_q, ser_d;
  logic          short_q, short_d;
  logic [PW-1:0] ext_q, ext_d;
  logic [PW-1:0] stop_q, stop_d;
  logic [PW-1:0] sb_q, sb_d;
  logic [FW-1:0] acc_q, acc_d;
  logic [PW-1:0] lh_q, ll_q;

  logic          store_bar;
  logic          rev;
  logic          new_ext;
  logic [PW-1:0] ext_run;
  logic [FW:0]   acc_sum;
  logic [FW-1:0] acc_cap, acc_run;
  logic          up;
  logic [PW-1:0] span;
  logic [MW-1:0] prod;
  logic [PW-1:0] q;
  logic          rem;
  logic [PW-1:0] t_move, t_clamp;
  logic          init_short;

  assign store_bar = series_start_i || (ser_q == SER_NONE);

  // reversal and new extreme for the running case
  assign rev     = short_q ? (high_i >= stop_q) : (low_i <= stop_q);
  assign new_ext = short_q ? (low_i < ext_q) : (high_i > ext_q);
  assign ext_run = new_ext ? (short_q ? low_i : high_i) : ext_q;

  // acceleration bump, capped at the limit
  assign acc_sum = {1'b0, acc_q} + {1'b0, accel_step_i};
  assign acc_cap = (acc_sum > {1'b0, accel_limit_i}) ? accel_limit_i : acc_sum[FW-1:0];
  assign acc_run = new_ext ? acc_cap : acc_q;

  // previous stop moved toward the extreme by the scaled distance, new stop rounded down
  assign up   = ext_run >= sb_q;
  assign span = up ? (ext_run - sb_q) : (sb_q - ext_run);
  assign prod = MW'(span) * MW'(acc_run);
  assign q    = prod[MW-1:FW];
  assign rem  = |prod[FW-1:0];
  assign t_move = up ? (sb_q + q) : (sb_q - q - PW'(rem));

  // clamp by this bar and the one before
  always_comb begin
    t_clamp = t_move;
    if (short_q) begin
      if (t_move < high_i) t_clamp = (lh_q > high_i) ? lh_q : high_i;
    end else begin
      if (t_move > low_i) t_clamp = (ll_q < low_i) ? ll_q : low_i;
    end
  end

  assign init_short = !(high_i > lh_q);

  // next state
  always_comb begin
    ser_d   = ser_q;
    short_d = short_q;
    ext_d   = ext_q;
    stop_d  = stop_q;
    sb_d    = sb_q;
    acc_d   = acc_q;
    flags_o = '0;
    if (store_bar) begin
      ser_d = SER_FIRST;
    end else if (ser_q == SER_FIRST) begin
      ser_d   = SER_RUN;
      short_d = init_short;
      ext_d   = init_short ? ((lh_q > high_i) ? lh_q : high_i)
                           : ((ll_q < low_i) ? ll_q : low_i);
      stop_d  = ext_d;
      sb_d    = ext_d;
      acc_d   = accel_start_i;
      flags_o.valid = 1'b1;
    end else if (rev) begin
      short_d = !short_q;
      ext_d   = short_q ? high_i : low_i;
      stop_d  = ext_q;
      sb_d    = ext_q;
      acc_d   = accel_start_i;
      flags_o.valid    = 1'b1;
      flags_o.reversed = 1'b1;
    end else begin
      ext_d  = ext_run;
      acc_d  = acc_run;
      sb_d   = stop_q;
      stop_d = t_clamp;
      flags_o.valid = 1'b1;
    end
    flags_o.is_short = short_d;
  end

  assign stop_level_o = stop_d;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_q   <= SER_NONE;
      short_q <= 1'b0;
    end else if (fire_i) begin
      ser_q   <= ser_d;
      short_q <= short_d;
    end
  end

  // price and acceleration state, only read once a series has started
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      ext_q  <= ext_d;
      stop_q <= stop_d;
      sb_q   <= sb_d;
      acc_q  <= acc_d;
      lh_q   <= high_i;
      ll_q   <= low_i;
    end
  end

endmodule

`default_nettype wire

### src/parabolic_stop_and_reverse_unit.sv
// Parabolic stop-and-reverse unit, top level: bar register, core, result register.
// Depends on sar_pkg, sar_if, sar_cfg, sar_core and the assertion macro header.
//
// Usage
//   bar_i  : one request per price bar (bar_high, bar_low, series_start).
//   sar_o  : one request per result (stop_level, is_short, reversed).
//   cfg_*  : write port for accel_start, accel_step and accel_limit (Q0.F);
//            write only while no bar is in flight.
// The first bar of a series is stored and gives no result; every later bar
// gives exactly one. A bar is registered on acceptance; the recurrence runs on
// the bar register once the result register has room, and its result is
// registered into the result register, which drives sar_o.valid. One bar per
// cycle is sustained while sar_o does not stall; the limit is the state update
// (compare, one multiply, clamp) feeding its own state registers.
// Reset clears the series state, so the next bar starts a series, and loads
// the acceleration registers with their defaults (0.02, 0.02, 0.2).
// When sar_o stalls, the result register holds and one more bar is taken
// into the bar register; bar_i.ready then drops until sar_o moves.
`default_nettype none
`include "parabolic_stop_and_reverse_unit_macros.svh"

module parabolic_stop_and_reverse_unit #(
  parameter int unsigned PRICE_BITS      = 32,
  parameter int unsigned ACCEL_FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  sar_bar_if.sink                            bar_i,
  sar_res_if.source                          sar_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sar_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sar_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic                       in_valid_q, in_valid_d;
  logic [PRICE_BITS-1:0]      in_high_q, in_low_q;
  logic                       in_start_q;
  logic                       fire;
  logic                       take_bar;

  logic [ACCEL_FRAC_BITS-1:0] accel_start, accel_step, accel_limit;
  logic [PRICE_BITS-1:0]      core_stop;
  sar_pkg::sar_flags_t        core_flags;

  logic                       out_valid_q, out_valid_d;
  logic [PRICE_BITS-1:0]      out_stop_q;
  logic                       out_short_q, out_rev_q;

  // configuration registers
  sar_cfg #(
    .ACCEL_FRAC_BITS(ACCEL_FRAC_BITS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .accel_start_o(accel_start),
    .accel_step_o (accel_step),
    .accel_limit_o(accel_limit)
  );

  // bar register advances when the result register has room
  assign fire       = in_valid_q && (!out_valid_q || sar_o.ready);
  assign bar_i.ready = !in_valid_q || fire;
  assign take_bar   = bar_i.valid && bar_i.ready;
  assign in_valid_d = take_bar || (in_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_bar) begin
      in_high_q  <= bar_i.bar_high;
      in_low_q   <= bar_i.bar_low;
      in_start_q <= bar_i.series_start;
    end
  end

  // recurrence
  sar_core #(
    .PRICE_BITS     (PRICE_BITS),
    .ACCEL_FRAC_BITS(ACCEL_FRAC_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .high_i        (in_high_q),
    .low_i         (in_low_q),
    .series_start_i(in_start_q),
    .accel_start_i (accel_start),
    .accel_step_i  (accel_step),
    .accel_limit_i (accel_limit),
    .stop_level_o  (core_stop),
    .flags_o       (core_flags)
  );

  // result register
  assign out_valid_d = fire ? core_flags.valid : (out_valid_q && !sar_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && core_flags.valid) begin
      out_stop_q  <= core_stop;
      out_short_q <= core_flags.is_short;
      out_rev_q   <= core_flags.reversed;
    end
  end

  assign sar_o.valid      = out_valid_q;
  assign sar_o.stop_level = out_stop_q;
  assign sar_o.is_short   = out_short_q;
  assign sar_o.reversed   = out_rev_q;

  // checks
  `SAR_ASSERT_NOW(a_res_from_bar, $rose(out_valid_q), $past(fire), "result without a bar")
  `SAR_ASSERT_NEXT(a_bar_held, in_valid_q && !fire, in_valid_q, "stalled bar lost")
  `SAR_ASSERT_NOW(a_ready_low, !bar_i.ready, in_valid_q && out_valid_q && !sar_o.ready, "ready low")

endmodule

`default_nettype wire
